/* hw/rtl/lmsrc_pkg.sv */
// Package for the scrolling LED matrix row composer.
// Font store geometry, register map, request codes, sequencer states and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lmsrc_pkg;

    // font store size in bytes (512 .. 8192)
    localparam int FONT_BYTES = 2048;
    localparam int FONT_AW    = $clog2(FONT_BYTES);

    // glyph index (7b) + side (1b) + row (4b)
    localparam int GLYPH_AW = 12;
    localparam int EXT_AW   = (FONT_AW > GLYPH_AW) ? FONT_AW : GLYPH_AW;

    localparam int BLANK_GLYPHS = 4;
    localparam int ROW_BYTES    = 10;
    localparam int PADDR_W      = 3;

    localparam logic [7:0] TPS_RESET = 8'd40;
    localparam logic [3:0] RD_LAST   = 4'(ROW_BYTES - 1);

    // register index (paddr[2])
    localparam logic REG_GLYPH_COUNT = 1'b0;
    localparam logic REG_TICKS       = 1'b1;

    // req_type codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_LOAD
    } lmsrc_state_t;

    typedef struct packed {
        logic               we;
        logic [FONT_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [FONT_AW-1:0] raddr;
        logic               blank;
    } lmsrc_mem_req_t;

endpackage

`default_nettype wire

/* hw/rtl/lmsrc_font_store.sv */
// Font store: single-port-write, single-port-read synchronous RAM, registered read.
// Blank reads (empty glyph position or address past the store) return zero.
// Depends on lmsrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmsrc_font_store (
    input  wire                     clk,
    input  lmsrc_pkg::lmsrc_mem_req_t req,
    output logic [7:0]              rdata
);
    import lmsrc_pkg::*;

    logic [7:0] mem [FONT_BYTES];
    logic [7:0] q_reg;
    logic       blank_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            q_reg     <= mem[req.raddr];
            blank_reg <= req.blank;
        end
    end

    assign rdata = blank_reg ? 8'h00 : q_reg;

endmodule

`default_nettype wire

/* hw/rtl/led_matrix_scroll_row_composer.sv */
// Top level of the scrolling LED matrix row composer (16 rows x 64 pixels, 16x16 glyphs).
// Holds scroll counters, config registers and the row read sequencer; font RAM in
// lmsrc_font_store. Depends on lmsrc_pkg and lmsrc_font_store.
//
//   channel | handshake                     | payload
//   --------+-------------------------------+----------------------------------
//   in      | in_valid / in_ready           | req_type, font_addr, font_byte
//   out     | out_valid / out_ready         | row_select, row_bits
//   cfg     | APB psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// A font write transfer puts the byte into the RAM at the accept edge.
// A tick transfer: accept, ten font RAM reads in ST_READ (one per cycle through the
// single read port), ST_DRAIN for the last read data, ST_LOAD to load the output register.
// A new item is taken only when the sequencer is idle; a finished row may still wait in
// the output register, and a following tick stalls in its load step until it drains.
// Reset clears counters and glyph count, loads TPS_RESET; font RAM undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module led_matrix_scroll_row_composer (
    input  wire                              clk,
    input  wire                              rst_n,
    // item input
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire                              req_type,
    input  wire  [10:0]                      font_addr,
    input  wire  [7:0]                       font_byte,
    // row output
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [3:0]                       row_select,
    output logic [63:0]                      row_bits,
    // config port
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [lmsrc_pkg::PADDR_W-1:0]    paddr,
    input  wire  [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import lmsrc_pkg::*;

    // config registers
    logic [6:0] glyph_count_reg;
    logic [7:0] ticks_per_shift_reg;

    // scroll state
    logic [3:0] row_counter_reg,    row_counter_next;
    logic [7:0] tick_counter_reg,   tick_counter_next;
    logic [3:0] bit_offset_reg,     bit_offset_next;
    logic [6:0] glyph_position_reg, glyph_position_next;

    // per-tick snapshot
    logic [3:0] cur_row_reg;
    logic [3:0] cur_off_reg;
    logic [6:0] cur_pos_reg;

    // sequencer
    lmsrc_state_t state_reg, state_next;
    logic [3:0]   rd_idx_reg, rd_idx_next;
    logic         rvalid_reg;
    logic [79:0]  buf_reg;

    // output register
    logic         out_valid_reg, out_valid_next;
    logic [3:0]   row_select_reg;
    logic [63:0]  row_bits_reg;

    logic              accept;
    logic              tick_acc;
    logic              out_load;
    lmsrc_mem_req_t    mem_req;
    logic [7:0]        rdata;

    // read address generation
    logic [7:0]          rd_pos;
    logic [7:0]          rd_glyph;
    logic                rd_pos_ok;
    logic [GLYPH_AW-1:0] rd_addr;
    logic [EXT_AW-1:0]   rd_addr_ext;
    logic [EXT_AW-1:0]   wr_addr_ext;
    logic [87:0]         stream;

    // scroll step helpers
    logic [7:0] tick_inc;
    logic [4:0] off_inc;
    logic [6:0] pos_inc;

    assign pready   = 1'b1;
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign tick_acc = accept && (req_type == REQ_TICK);

    // ---------------------------------------------------------------------
    // Config port: register index is paddr[2]
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_count_reg     <= '0;
            ticks_per_shift_reg <= TPS_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                REG_GLYPH_COUNT: glyph_count_reg     <= pwdata[6:0];
                REG_TICKS:       ticks_per_shift_reg <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_GLYPH_COUNT: prdata = {25'd0, glyph_count_reg};
            REG_TICKS:       prdata = {24'd0, ticks_per_shift_reg};
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Scroll counters: advanced at the tick accept, before the row is composed
    // ---------------------------------------------------------------------
    always_comb
    begin
        tick_inc            = tick_counter_reg + 8'd1;
        off_inc             = {1'b0, bit_offset_reg} + 5'd1;
        pos_inc             = glyph_position_reg + 7'd1;
        tick_counter_next   = tick_inc;
        bit_offset_next     = bit_offset_reg;
        glyph_position_next = glyph_position_reg;
        if (tick_inc == ticks_per_shift_reg)
        begin
            tick_counter_next = '0;
            bit_offset_next   = off_inc[3:0];
            if (off_inc[4])
            begin
                // wrap at glyph_count + 4 leading blanks
                if ({1'b0, pos_inc} >= ({1'b0, glyph_count_reg} + 8'(BLANK_GLYPHS)))
                begin
                    glyph_position_next = '0;
                end
                else
                begin
                    glyph_position_next = pos_inc;
                end
            end
        end
        row_counter_next = row_counter_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_counter_reg    <= '0;
            tick_counter_reg   <= '0;
            bit_offset_reg     <= '0;
            glyph_position_reg <= '0;
        end
        else if (tick_acc)
        begin
            row_counter_reg    <= row_counter_next;
            tick_counter_reg   <= tick_counter_next;
            bit_offset_reg     <= bit_offset_next;
            glyph_position_reg <= glyph_position_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            cur_row_reg <= row_counter_reg;
            cur_off_reg <= bit_offset_next;
            cur_pos_reg <= glyph_position_next;
        end
    end

    // ---------------------------------------------------------------------
    // Font RAM requests. Read k: glyph slot k/2, left byte on even k, right on odd.
    // ---------------------------------------------------------------------
    always_comb
    begin
        rd_pos      = {1'b0, cur_pos_reg} + {5'd0, rd_idx_reg[3:1]};
        rd_glyph    = rd_pos - 8'(BLANK_GLYPHS);
        rd_pos_ok   = (rd_pos >= 8'(BLANK_GLYPHS)) && (rd_glyph < {1'b0, glyph_count_reg});
        rd_addr     = {rd_glyph[6:0], rd_idx_reg[0], cur_row_reg};
        rd_addr_ext = EXT_AW'(rd_addr);
        wr_addr_ext = EXT_AW'(font_addr);

        mem_req.we    = accept && (req_type == REQ_WRITE) && (int'(wr_addr_ext) < FONT_BYTES);
        mem_req.waddr = wr_addr_ext[FONT_AW-1:0];
        mem_req.wdata = font_byte;
        mem_req.re    = (state_reg == ST_READ);
        mem_req.raddr = rd_addr_ext[FONT_AW-1:0];
        mem_req.blank = !(rd_pos_ok && (int'(rd_addr_ext) < FONT_BYTES));
    end

    lmsrc_font_store u_font_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_idx_next = '0;
                if (tick_acc)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                rd_idx_next = rd_idx_reg + 4'd1;
                if (rd_idx_reg == RD_LAST)
                begin
                    rd_idx_next = '0;
                    state_next  = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_idx_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            rvalid_reg <= mem_req.re;
        end
    end

    // bytes arrive in order; after ten shifts byte 0 sits in the low byte
    always_ff @(posedge clk)
    begin
        if (rvalid_reg)
        begin
            buf_reg <= {rdata, buf_reg[79:8]};
        end
    end

    // funnel shift: 64 bits of the zero-padded stream starting at the bit offset
    assign stream = {8'h00, buf_reg} >> cur_off_reg;

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            row_select_reg <= 4'd15 - cur_row_reg;
            row_bits_reg   <= stream[63:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_select = row_select_reg;
    assign row_bits   = row_bits_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_rd_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_idx_reg <= RD_LAST)
        else $error("read index past last row byte");

    a_rdata_window: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg |-> (state_reg == ST_READ || state_reg == ST_DRAIN))
        else $error("font read data outside read window");

    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_LOAD))
        else $error("row result raised outside load step");

    a_tick_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        tick_acc |=> (state_reg == ST_READ && rd_idx_reg == 4'd0))
        else $error("tick did not start the read sweep");

endmodule

`default_nettype wire

/* tb/lmsrc_row_checker.sv */
// Row checker for the scrolling LED matrix row composer.
// Watches the item, row and APB channels, keeps its own font copy and scroll state,
// and compares every row transfer and register read. Depends on lmsrc_pkg.
`timescale 1ns / 1ps

module lmsrc_row_checker (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    input  wire                           in_ready,
    input  wire                           req_type,
    input  wire  [10:0]                   font_addr,
    input  wire  [7:0]                    font_byte,
    input  wire                           out_valid,
    input  wire                           out_ready,
    input  wire  [3:0]                    row_select,
    input  wire  [63:0]                   row_bits,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [lmsrc_pkg::PADDR_W-1:0] paddr,
    input  wire  [31:0]                   pwdata,
    input  wire  [31:0]                   prdata,
    input  wire                           pready,
    output int                            pending,
    output int                            errors,
    output int                            rows_checked
);
    import lmsrc_pkg::*;

    typedef struct packed {
        logic [3:0]  row_select;
        logic [63:0] row_bits;
    } scan_row_t;

    logic [7:0] font_copy [0:FONT_BYTES-1];
    logic [6:0] glyph_count_q;
    logic [7:0] ticks_per_shift_q;
    logic [3:0] scan_row;
    logic [7:0] tick_cnt;
    logic [3:0] pixel_offset;
    logic [6:0] glyph_pos;
    scan_row_t  expected_rows[$];
    scan_row_t  want;

    function automatic logic [7:0] font_byte_at(int addr);
        return (addr < FONT_BYTES) ? font_copy[addr] : 8'h00;
    endfunction

    // five glyph slots -> 80-bit strip, byte 0 lowest; window of 64 at pixel_offset
    function automatic logic [63:0] compose_row();
        logic [79:0] strip;
        int          pos;
        int          base;
        strip = '0;
        for (int j = 0; j < 5; j++)
        begin
            pos = int'(glyph_pos) + j;
            if (pos >= BLANK_GLYPHS && pos - BLANK_GLYPHS < int'(glyph_count_q))
            begin
                base = (pos - BLANK_GLYPHS) * 32 + int'(scan_row);
                strip[16*j +: 8]   = font_byte_at(base);
                strip[16*j+8 +: 8] = font_byte_at(base + 16);
            end
        end
        strip = strip >> pixel_offset;
        return strip[63:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_count_q     = '0;
            ticks_per_shift_q = TPS_RESET;
            scan_row          = '0;
            tick_cnt          = '0;
            pixel_offset      = '0;
            glyph_pos         = '0;
            expected_rows.delete();
            pending           = 0;
            errors            = 0;
            rows_checked      = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_GLYPH_COUNT)
                        glyph_count_q = pwdata[6:0];
                    else
                        ticks_per_shift_q = pwdata[7:0];
                end
                else if (paddr[2] == REG_GLYPH_COUNT)
                begin
                    if (prdata[6:0] !== glyph_count_q)
                    begin
                        $error("glyph_count readback: expected %0d, got %0d",
                               glyph_count_q, prdata[6:0]);
                        errors++;
                    end
                end
                else if (prdata[7:0] !== ticks_per_shift_q)
                begin
                    $error("ticks_per_shift readback: expected %0d, got %0d",
                           ticks_per_shift_q, prdata[7:0]);
                    errors++;
                end
            end

            if (out_valid && out_ready)
            begin
                if (expected_rows.size() == 0)
                begin
                    $error("row transfer with none pending: row_select %0d row_bits %h",
                           row_select, row_bits);
                    errors++;
                end
                else
                begin
                    want = expected_rows.pop_front();
                    rows_checked++;
                    if (row_select !== want.row_select)
                    begin
                        $error("row_select: expected %0d, got %0d", want.row_select, row_select);
                        errors++;
                    end
                    if (row_bits !== want.row_bits)
                    begin
                        $error("row_bits: expected %h, got %h", want.row_bits, row_bits);
                        errors++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                if (req_type == REQ_WRITE)
                begin
                    if (int'(font_addr) < FONT_BYTES)
                        font_copy[font_addr] = font_byte;
                end
                else
                begin
                    // scroll first, then compose from the new offsets
                    tick_cnt = tick_cnt + 8'd1;
                    if (tick_cnt == ticks_per_shift_q)
                    begin
                        tick_cnt = '0;
                        if (pixel_offset == 4'd15)
                        begin
                            pixel_offset = '0;
                            glyph_pos    = glyph_pos + 7'd1;
                            if (int'(glyph_pos) >= int'(glyph_count_q) + BLANK_GLYPHS)
                                glyph_pos = '0;
                        end
                        else
                            pixel_offset = pixel_offset + 4'd1;
                    end
                    want.row_select = 4'd15 - scan_row;
                    want.row_bits   = compose_row();
                    expected_rows.push_back(want);
                    scan_row = scan_row + 4'd1;
                end
            end
            pending = expected_rows.size();
        end
    end

endmodule

/* tb/tb.sv */
// Testbench top for the scrolling LED matrix row composer.
// Drives items, APB register writes and read-backs, and row backpressure; lmsrc_row_checker does the
// prediction and comparison. Depends on lmsrc_pkg, the block and lmsrc_row_checker.
`timescale 1ns / 1ps

module tb;
    import lmsrc_pkg::*;

    // glyphs loaded into the font store before any row reads glyph data
    localparam int FILL_GLYPHS = 8;

    // receiver behavior, re-chosen at the end of each random-length stretch
    typedef enum int {
        RX_STREAM,   // always ready
        RX_COIN,     // ready half the time
        RX_CHOKE     // ready with probability one in eight
    } rx_mode_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                req_type  = REQ_WRITE;
    logic [10:0]         font_addr = '0;
    logic [7:0]          font_byte = '0;
    logic                out_ready = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [31:0]         pwdata    = '0;

    wire                 in_ready;
    wire                 out_valid;
    wire  [3:0]          row_select;
    wire  [63:0]         row_bits;
    wire  [31:0]         prdata;
    wire                 pready;

    int                  pending;
    int                  errors;
    int                  rows_checked;

    int                  burst_left   = 0;
    int                  writes_sent  = 0;
    int                  ticks_sent   = 0;
    int                  settings_run = 1;   // reset values count as the first setting
    rx_mode_t            rx_mode      = RX_STREAM;
    int                  rx_mode_left = 0;

    led_matrix_scroll_row_composer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .font_addr  (font_addr),
        .font_byte  (font_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .row_select (row_select),
        .row_bits   (row_bits),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    lmsrc_row_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .font_addr    (font_addr),
        .font_byte    (font_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .row_select   (row_select),
        .row_bits     (row_bits),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pending      (pending),
        .errors       (errors),
        .rows_checked (rows_checked)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Run limit: far above the slowest legal run (under 900 transfers, each with
    // a full tick sweep, a sender gap and a long receiver choke on top).
    initial
    begin
        #20_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // Row backpressure: one mode per stretch, so long choked and fully open
    // stretches both occur and stalls land on the load step of the read sequencer.
    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      <= rx_mode_t'($urandom_range(0, 2));
            rx_mode_left <= $urandom_range(16, 96);
        end
        else
            rx_mode_left <= rx_mode_left - 1;

        case (rx_mode)
            RX_STREAM: out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            default:   out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // One item transfer. The sender runs in bursts; between bursts valid drops
    // for a random gap (sometimes none, so back-to-back stretches happen too).
    // Valid is left high after a transfer so the next call can keep it up
    // without a low/high pair in the same step.
    task automatic push_item(input logic kind, input logic [10:0] addr, input logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 32);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        req_type  <= kind;
        font_addr <= addr;
        font_byte <= data;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        if (kind == REQ_TICK)
            ticks_sent++;
        else
            writes_sent++;
    endtask

    // Stop sending until every predicted row has come out. The first edge lets
    // the checker book a tick that was taken in this very step. The extra
    // cycles cover a trailing font write, which yields no row.
    task automatic drain_rows();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        burst_left = 0;
    endtask

    // APB write, then a read-back of the same register (checked by the checker).
    // Each transfer has a setup and an access phase; pready is always high.
    task automatic set_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One register setting followed by random traffic: mostly ticks (with junk
    // in the unused address and byte fields), some font rewrites anywhere.
    task automatic run_phase(input logic [6:0] glyphs, input logic [7:0] period, input int n_items);
        drain_rows();
        set_reg(REG_GLYPH_COUNT, {25'd0, glyphs});
        set_reg(REG_TICKS, {24'd0, period});
        settings_run++;
        for (int k = 0; k < n_items; k++)
        begin
            // long phases stop once midway until every row is out
            if (k == n_items / 2 && n_items >= 120)
                drain_rows();
            if ($urandom_range(0, 99) < 85)
                push_item(REQ_TICK, 11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)));
            else
                push_item(REQ_WRITE, 11'($urandom_range(0, FONT_BYTES - 1)),
                          8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting (no glyphs, period 40): address and byte extremes, then
        // exactly one period of blank rows, so the tick counter matches and is
        // back at zero before the first register change.
        push_item(REQ_WRITE, 11'd0,    8'h00);
        push_item(REQ_WRITE, 11'd2047, 8'hFF);
        push_item(REQ_WRITE, 11'h555,  8'hAA);
        push_item(REQ_WRITE, 11'h2AA,  8'h55);
        for (int k = 0; k < 40; k++)
            push_item(REQ_TICK, 11'h7FF, 8'hFF);

        // Fill the first glyphs. The phases below keep the glyph position low
        // enough that no row ever reaches a glyph past these.
        for (int a = 0; a < FILL_GLYPHS * 32; a++)
            push_item(REQ_WRITE, 11'(a), 8'($urandom_range(0, 255)));

        // One glyph, shift every tick: glyph 0 slides in from the right edge.
        run_phase(7'd1, 8'd1, 24);
        // Eight glyphs, fastest scroll: glyph position climbs through the text.
        run_phase(7'(FILL_GLYPHS), 8'd1, 140);
        // Count lowered below the position: wraps to 0 at next advance, then
        // wraps regularly at count plus four.
        run_phase(7'd2, 8'd1, 40);
        // Slowest nonzero period: tick counter climbs without matching.
        run_phase(7'd3, 8'd255, 130);
        // Period zero, set below the running count: counter wraps past 255
        // before it matches.
        run_phase(7'd3, 8'd0, 190);
        // No glyphs at all: every row blank whatever the offsets.
        run_phase(7'd0, 8'd7, 24);
        // Glyph count 64 and the largest period, 255.
        run_phase(7'd64, 8'd255, 24);

        drain_rows();

        $display("tb: sent %0d font writes and %0d row ticks under %0d register settings",
                 writes_sent, ticks_sent, settings_run);
        $display("tb: compared %0d rows; glyph counts 0 to 64, shift periods 0 to 255",
                 rows_checked);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/lmsrc_pkg.sv
hw/rtl/lmsrc_font_store.sv
hw/rtl/led_matrix_scroll_row_composer.sv
tb/lmsrc_row_checker.sv
tb/tb.sv
